FILE: design/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

  localparam int unsigned MaxSegmentsDef = 64;
  localparam logic [15:0] CapacityReset  = 16'd1024;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_COMPACT = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADSIZE  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] size;
    logic [15:0] address;
  } req_t;

  typedef struct packed {
    logic [15:0] start_res;
    logic [2:0]  status;
  } res_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] length;
    logic        free;
  } seg_t;

endpackage

`default_nettype wire

FILE: design/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/first_fit_segment_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// First-fit allocator over an ordered segment table held in one RAM.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; its result is
// shown for one cycle with done_o and cannot be held off. The table is walked
// one entry at a time (RAM read, then check); a split of an entry first shifts
// the later entries up by one place (read, then write each) and then writes the
// two halves, and compact walks every entry. Bad sizes and the unused opcode
// are answered from idle without a table walk. After reset and after each
// capacity write the block is busy while it writes the first entry.
`default_nettype none

module first_fit_segment_allocator_core #(
  parameter int unsigned MaxSegments = ffsa_pkg::MaxSegmentsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire ffsa_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output ffsa_pkg::res_t     res_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);

  localparam int unsigned IW = $clog2(MaxSegments);
  localparam int unsigned CW = $clog2(MaxSegments + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MaxSegments);
  localparam logic [CW-1:0] One = CW'(1);

  typedef enum logic [10:0] {
    S_INIT   = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_RD     = 11'b00000000100,
    S_CHK    = 11'b00000001000,
    S_SH_RD  = 11'b00000010000,
    S_SH_WR  = 11'b00000100000,
    S_SP_WR1 = 11'b00001000000,
    S_SP_WR0 = 11'b00010000000,
    S_CP_RD  = 11'b00100000000,
    S_CP_CHK = 11'b01000000000,
    S_CP_END = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [15:0]    cap_q;
  logic [CW-1:0]  cnt_q, cnt_d, idx_q, idx_d, k_q, k_d, w_q, w_d;
  ffsa_pkg::req_t req_q, req_d;
  ffsa_pkg::seg_t ent_q, ent_d, rdata;
  ffsa_pkg::res_t res_q, res_d;
  logic           valid_q, valid_d;
  logic           we;
  logic [IW-1:0]  waddr, raddr;
  ffsa_pkg::seg_t wdata;
  logic           cfg_wr, cap_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cap_wr = cfg_wr && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {16'd0, cap_q};
  assign busy_o = (state_q != S_IDLE) || cfg_wr;
  assign done_o = valid_q;
  assign res_o  = res_q;

  ffsa_ram #(
    .Width($bits(ffsa_pkg::seg_t)),
    .Depth(MaxSegments)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    k_d     = k_q;
    w_d     = w_q;
    req_d   = req_q;
    ent_d   = ent_q;
    res_d   = res_q;
    valid_d = 1'b0;
    we      = 1'b0;
    waddr   = idx_q[IW-1:0];
    wdata   = rdata;
    raddr   = idx_q[IW-1:0];
    unique case (state_q)
      S_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = '{start: 16'd0, length: cap_q, free: 1'b1};
        cnt_d   = One;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i && !cfg_wr) begin
          req_d = req_i;
          idx_d = '0;
          w_d   = '0;
          res_d = '{start_res: 16'd0, status: ffsa_pkg::ST_OK};
          unique case (req_i.opcode)
            ffsa_pkg::OP_ALLOC: begin
              if (req_i.size == 16'd0) begin
                res_d.status = ffsa_pkg::ST_BADSIZE;
                valid_d      = 1'b1;
              end else begin
                state_d = S_RD;
              end
            end
            ffsa_pkg::OP_FREE:    state_d = S_RD;
            ffsa_pkg::OP_COMPACT: state_d = S_CP_RD;
            default:              valid_d = 1'b1;
          endcase
        end
      end
      S_RD: begin
        if (idx_q == cnt_q) begin
          res_d.status = (req_q.opcode == ffsa_pkg::OP_ALLOC) ?
                         ffsa_pkg::ST_NOFIT : ffsa_pkg::ST_NOTFOUND;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        idx_d   = idx_q + One;
        state_d = S_RD;
        if (req_q.opcode == ffsa_pkg::OP_ALLOC) begin
          if (rdata.free && (rdata.length >= req_q.size)) begin
            idx_d = idx_q;
            if (rdata.length == req_q.size) begin
              we              = 1'b1;
              wdata.free      = 1'b0;
              res_d.start_res = rdata.start;
              valid_d         = 1'b1;
              state_d         = S_IDLE;
            end else if (cnt_q == MaxCount) begin
              res_d.status = ffsa_pkg::ST_FULL;
              valid_d      = 1'b1;
              state_d      = S_IDLE;
            end else begin
              ent_d   = rdata;
              k_d     = cnt_q;
              state_d = (cnt_q == idx_q + One) ? S_SP_WR1 : S_SH_RD;
            end
          end
        end else if (rdata.start == req_q.address) begin
          we         = 1'b1;
          wdata.free = 1'b1;
          valid_d    = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_SH_RD: begin
        raddr   = IW'(k_q - One);
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        we      = 1'b1;
        waddr   = k_q[IW-1:0];
        k_d     = k_q - One;
        state_d = (k_q - One == idx_q + One) ? S_SP_WR1 : S_SH_RD;
      end
      S_SP_WR1: begin
        we      = 1'b1;
        waddr   = IW'(idx_q + One);
        wdata   = '{start: ent_q.start + req_q.size,
                    length: ent_q.length - req_q.size, free: 1'b1};
        state_d = S_SP_WR0;
      end
      S_SP_WR0: begin
        we              = 1'b1;
        wdata           = '{start: ent_q.start, length: req_q.size, free: 1'b0};
        cnt_d           = cnt_q + One;
        res_d.start_res = ent_q.start;
        valid_d         = 1'b1;
        state_d         = S_IDLE;
      end
      S_CP_RD: begin
        state_d = (idx_q == cnt_q) ? S_CP_END : S_CP_CHK;
      end
      S_CP_CHK: begin
        idx_d   = idx_q + One;
        state_d = S_CP_RD;
        if ((w_q != '0) && rdata.free && ent_q.free) begin
          ent_d.length = ent_q.length + rdata.length;
        end else begin
          we    = (w_q != '0);
          waddr = IW'(w_q - One);
          wdata = ent_q;
          ent_d = rdata;
          w_d   = w_q + One;
        end
      end
      S_CP_END: begin
        we      = 1'b1;
        waddr   = IW'(w_q - One);
        wdata   = ent_q;
        cnt_d   = w_q;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
    if (cap_wr) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cap_q   <= ffsa_pkg::CapacityReset;
      cnt_q   <= One;
      idx_q   <= '0;
      k_q     <= '0;
      w_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      w_q     <= w_d;
      valid_q <= valid_d;
      if (cap_wr) begin
        cap_q <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    ent_q <= ent_d;
    res_q <= res_d;
  end

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted transfer neither started nor finished");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status == ffsa_pkg::ST_FULL)) |-> (cnt_q == MaxCount))
    else $error("table full reported with free table slots");

  a_compact_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CP_CHK && we) |-> (CW'(waddr) < idx_q))
    else $error("compact write overtook its read pointer");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((cnt_q != '0) && (cnt_q <= MaxCount)))
    else $error("segment count out of range at result transfer");

endmodule

`default_nettype wire

FILE: sim/ffsa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffsa_checker
// Watches the request, result and register channels of the allocator, keeps
// its own copy of the segment table, predicts each result and compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_checker #(
  parameter int unsigned MaxSegments = ffsa_pkg::MaxSegmentsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic           busy_o,
  input  wire ffsa_pkg::req_t req_i,
  input  wire logic           done_o,
  input  wire ffsa_pkg::res_t res_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic           pready,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output int                  fail_count,
  output int                  pending_count
);

  logic [15:0]    capacity;
  ffsa_pkg::seg_t table_q [MaxSegments];
  int unsigned    seg_count;
  ffsa_pkg::res_t expected_results [$];

  function automatic void table_init();
    for (int i = 0; i < MaxSegments; i++) table_q[i] = '0;
    table_q[0].length = capacity;
    table_q[0].free   = 1'b1;
    seg_count = 1;
  endfunction

  function automatic ffsa_pkg::res_t compute_result(ffsa_pkg::req_t rq);
    ffsa_pkg::res_t r;
    int unsigned w;
    r = '0;
    r.status = ffsa_pkg::ST_OK;
    case (ffsa_pkg::opcode_e'(rq.opcode))
      ffsa_pkg::OP_ALLOC: begin
        if (rq.size == 16'd0) begin
          r.status = ffsa_pkg::ST_BADSIZE;
        end else begin
          r.status = ffsa_pkg::ST_NOFIT;
          for (int i = 0; i < seg_count; i++) begin
            if (!table_q[i].free || table_q[i].length < rq.size) continue;
            if (table_q[i].length == rq.size) begin
              table_q[i].free = 1'b0;
              r.start_res = table_q[i].start;
              r.status = ffsa_pkg::ST_OK;
            end else if (seg_count >= MaxSegments) begin
              r.status = ffsa_pkg::ST_FULL;
            end else begin
              for (int k = seg_count; k > i + 1; k--) table_q[k] = table_q[k-1];
              table_q[i+1].start  = table_q[i].start + rq.size;
              table_q[i+1].length = table_q[i].length - rq.size;
              table_q[i+1].free   = 1'b1;
              table_q[i].length   = rq.size;
              table_q[i].free     = 1'b0;
              seg_count++;
              r.start_res = table_q[i].start;
              r.status = ffsa_pkg::ST_OK;
            end
            break;
          end
        end
      end
      ffsa_pkg::OP_FREE: begin
        r.status = ffsa_pkg::ST_NOTFOUND;
        for (int i = 0; i < seg_count; i++) begin
          if (table_q[i].start == rq.address) begin
            table_q[i].free = 1'b1;
            r.status = ffsa_pkg::ST_OK;
            break;
          end
        end
      end
      ffsa_pkg::OP_COMPACT: begin
        w = 0;
        for (int i = 0; i < seg_count; i++) begin
          if (w > 0 && table_q[i].free && table_q[w-1].free) begin
            table_q[w-1].length = table_q[w-1].length + table_q[i].length;
          end else begin
            table_q[w] = table_q[i];
            w++;
          end
        end
        for (int i = w; i < MaxSegments; i++) table_q[i] = '0;
        seg_count = w;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ffsa_pkg::res_t ex;
    if (!rst_ni) begin
      capacity = ffsa_pkg::CapacityReset;
      table_init();
      expected_results.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transfer: %h", res_o);
        end else begin
          ex = expected_results.pop_front();
          if (res_o.start_res !== ex.start_res || res_o.status !== ex.status) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("result mismatch: expected start %0d status %0d, got start %0d status %0d",
                       ex.start_res, ex.status, res_o.start_res, res_o.status);
          end
        end
      end
      if (start_i && !busy_o)
        expected_results.insert(expected_results.size(), compute_result(req_i));
      if (psel && penable && pwrite && pready && !paddr[2]) begin
        capacity = pwdata[15:0];
        table_init();
      end
      pending_count <= expected_results.size();
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random allocate, free, compact and unused-opcode requests into the
// allocator, rewrites the capacity between phases and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  ffsa_pkg::req_t req_i = '0;
  logic           busy_o, done_o, pready;
  ffsa_pkg::res_t res_o;
  logic           psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0, prdata;
  int             fail_count, pending_count;
  logic [15:0]    granted [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  first_fit_segment_allocator_core dut (.*);
  ffsa_checker checker_i (.*);

  initial begin
    #200ms;
    $display("first_fit_segment_allocator_core: mismatch");
    $finish;
  end

  always @(posedge clk_i)
    if (done_o && res_o.status == ffsa_pkg::ST_OK && res_o.start_res != 0)
      granted.insert(granted.size(), res_o.start_res);

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [15:0] value);
    wait_drained();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {16'h0, value};
    @(negedge clk_i) penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    granted.delete();
    @(negedge clk_i);
  endtask

  task automatic send_request(ffsa_pkg::opcode_e op, logic [15:0] sz, logic [15:0] addr,
                              bit gap);
    if (gap) repeat ($urandom_range(0, 13)) @(negedge clk_i);
    start_i <= 1'b1;
    req_i <= '{opcode: op, size: sz, address: addr};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    start_i <= 1'b0;
    req_i <= '{opcode: 2'($urandom_range(0, 3)), size: 16'($urandom),
               address: 16'($urandom)};
  endtask

  task automatic random_phase(int n, logic [15:0] cap);
    int unsigned pick;
    logic [15:0] a;
    bit nogap;
    nogap = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) nogap = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 9) == 0) a = 16'($urandom);
        else a = 16'($urandom_range(1, (cap / 16) + 1));
        send_request(ffsa_pkg::OP_ALLOC, a, 16'($urandom), !nogap);
      end else if (pick < 80) begin
        a = 16'($urandom);
        if (granted.size() != 0 && $urandom_range(0, 4) != 0)
          a = granted[$urandom_range(0, granted.size() - 1)];
        else if ($urandom_range(0, 3) == 0) a = 16'd0;
        send_request(ffsa_pkg::OP_FREE, 16'($urandom), a, !nogap);
      end else if (pick < 95) begin
        send_request(ffsa_pkg::OP_COMPACT, 16'($urandom), 16'($urandom), !nogap);
      end else begin
        send_request(ffsa_pkg::OP_NONE, 16'($urandom), 16'($urandom), !nogap);
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_request(ffsa_pkg::OP_ALLOC, 16'd0, 16'd0, 1'b1);
    send_request(ffsa_pkg::OP_ALLOC, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(ffsa_pkg::OP_ALLOC, 16'd1024, 16'd0, 1'b1);
    send_request(ffsa_pkg::OP_FREE, 16'd0, 16'd0, 1'b1);
    send_request(ffsa_pkg::OP_FREE, 16'd0, 16'd0, 1'b1);
    send_request(ffsa_pkg::OP_FREE, 16'd0, 16'd7, 1'b1);
    send_request(ffsa_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 1'b1);
    for (int i = 0; i < 66; i++) send_request(ffsa_pkg::OP_ALLOC, 16'd1, 16'd0, 1'b0);
    send_request(ffsa_pkg::OP_FREE, 16'd0, 16'd3, 1'b0);
    send_request(ffsa_pkg::OP_FREE, 16'd0, 16'd4, 1'b0);
    send_request(ffsa_pkg::OP_COMPACT, 16'd0, 16'd0, 1'b0);
    send_request(ffsa_pkg::OP_ALLOC, 16'd1, 16'd0, 1'b0);
    write_capacity(16'd0);
    send_request(ffsa_pkg::OP_ALLOC, 16'd1, 16'd0, 1'b1);
    send_request(ffsa_pkg::OP_COMPACT, 16'd0, 16'd0, 1'b1);
    write_capacity(16'hFFFF);
    send_request(ffsa_pkg::OP_ALLOC, 16'hFFFF, 16'd0, 1'b1);
    send_request(ffsa_pkg::OP_FREE, 16'd0, 16'd0, 1'b1);
    random_phase(350, 16'hFFFF);
    write_capacity(16'd1);
    random_phase(150, 16'd1);
    write_capacity(16'd200);
    random_phase(350, 16'd200);
    wait_drained();
    write_capacity(16'd1024);
    random_phase(400, 16'd1024);
    write_capacity(16'd40000);
    random_phase(150, 16'd40000);
    wait_drained();
    if (fail_count == 0) begin
      $display("first_fit_segment_allocator_core: match");
    end else begin
      $display("first_fit_segment_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
